FILE: design/assert_macros.svh
// assertion macros shared by the design files
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check of a property at every rising clock edge
`define FRSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication from a trigger to a consequence in the same cycle
`define FRSA_ASSERT_IMP(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// implication from a trigger to a consequence in the next cycle
`define FRSA_ASSERT_NXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/frsa_pkg.sv
// shared types, constants and codes of the free range slot allocator
// used by frsa_cell and free_range_slot_allocator_unit, no dependencies
package frsa_pkg;

  // pool geometry
  localparam int NUM_SLOTS  = 256;
  localparam int MAX_RANGES = 128;

  // field widths of the stream payload
  localparam int SLOT_W   = 8;
  localparam int ALLOC_W  = 8;
  localparam int STATUS_W = 2;
  localparam int FS_W     = 9;

  // internal widths
  localparam int IDX_W  = $clog2(NUM_SLOTS);
  localparam int CMP_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int FREE_W = $clog2(NUM_SLOTS + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CMP_W-1:0] cmp_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 2'd0,
    ST_EXHAUSTED    = 2'd1,
    ST_ALREADY_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  // update broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INC_HEAD,
    OP_DROP_ALL,
    OP_MERGE,
    OP_SET_LAST,
    OP_SET_FIRST,
    OP_INSERT
  } cell_op_e;

  // one inclusive free range held by a cell
  typedef struct packed {
    logic valid;
    idx_t first;
    idx_t last;
  } range_t;

  // control from the sequencer to the cells
  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
    cmp_t     slot;
  } ctrl_t;

  // compare results held by each cell between the two steps
  typedef struct packed {
    logic le;
    logic pos;
    logic prev;
    logic hit;
    logic join_lo;
    logic join_hi;
  } flags_t;

endpackage

FILE: design/frsa_cell.sv
// one cell of the range chain: holds a single free range and its compare flags
// depends on frsa_pkg; neighbors exchange ranges for shifts in both directions
module frsa_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_i,
  input  frsa_pkg::ctrl_t   ctrl_i,
  input  frsa_pkg::range_t  left_i,
  input  frsa_pkg::range_t  right_i,
  input  logic              left_le_i,
  input  logic              right_le_i,
  output logic              le_o,
  output frsa_pkg::range_t  range_o,
  output frsa_pkg::flags_t  flags_o
);

  frsa_pkg::range_t range_q, range_d;
  frsa_pkg::flags_t flags_q, flags_d;
  frsa_pkg::cmp_t   first_x, last_x;

  // widen the stored bounds for compares against the slot
  assign first_x = frsa_pkg::CMP_W'(range_q.first);
  assign last_x  = frsa_pkg::CMP_W'(range_q.last);

  // compare step: place of the slot relative to this range
  always_comb begin
    flags_d.le      = range_q.valid && (first_x <= ctrl_i.slot);
    flags_d.pos     = !flags_d.le && left_le_i;
    flags_d.prev    = flags_d.le && !right_le_i;
    flags_d.hit     = flags_d.le && (ctrl_i.slot <= last_x);
    flags_d.join_lo = flags_d.prev && ((last_x + frsa_pkg::CMP_W'(1)) == ctrl_i.slot);
    flags_d.join_hi = flags_d.pos && range_q.valid &&
                      (first_x == (ctrl_i.slot + frsa_pkg::CMP_W'(1)));
  end

  // update step: local edit or shift toward a neighbor
  always_comb begin
    range_d = range_q;
    case (ctrl_i.op)
      frsa_pkg::OP_INC_HEAD: begin
        if (head_i) begin
          range_d.first = range_q.first + frsa_pkg::IDX_W'(1);
        end
      end
      frsa_pkg::OP_DROP_ALL: begin
        range_d = right_i;
      end
      frsa_pkg::OP_MERGE: begin
        if (flags_q.prev) begin
          range_d.last = right_i.last;
        end else if (!flags_q.le) begin
          range_d = right_i;
        end
      end
      frsa_pkg::OP_SET_LAST: begin
        if (flags_q.prev) begin
          range_d.last = ctrl_i.slot[frsa_pkg::IDX_W-1:0];
        end
      end
      frsa_pkg::OP_SET_FIRST: begin
        if (flags_q.pos) begin
          range_d.first = ctrl_i.slot[frsa_pkg::IDX_W-1:0];
        end
      end
      frsa_pkg::OP_INSERT: begin
        if (flags_q.pos) begin
          range_d.valid = 1'b1;
          range_d.first = ctrl_i.slot[frsa_pkg::IDX_W-1:0];
          range_d.last  = ctrl_i.slot[frsa_pkg::IDX_W-1:0];
        end else if (!flags_q.le) begin
          range_d = left_i;
        end
      end
      default: begin
        range_d = range_q;
      end
    endcase
  end

  // range storage, the head cell starts out holding the whole pool
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q.valid <= head_i;
      range_q.first <= '0;
      range_q.last  <= head_i ? frsa_pkg::IDX_W'(frsa_pkg::NUM_SLOTS - 1) : '0;
    end else begin
      range_q <= range_d;
    end
  end

  // compare flags, loaded in the compare step only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctrl_i.cmp_en) begin
      flags_q <= flags_d;
    end
  end

  assign le_o    = flags_d.le;
  assign range_o = range_q;
  assign flags_o = flags_q;

endmodule

FILE: design/free_range_slot_allocator_unit.sv
// top level of the free range slot allocator: sequencer, cell chain, result register
// depends on frsa_pkg, frsa_cell and assert_macros.svh
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tuser: cmd, tdata: free_index
//  m_axis    out  m_axis_tvalid/tready    tuser: status, tdata: alloc_index, free_slots
//
// every command runs a compare step in all cells, then an update step
// in which the cells edit or shift their ranges in one go and the result is registered
// a new command is taken in the update step of the previous one,
// as long as the result side keeps up
// a result that is not taken holds the update step, and with it the input side
// after reset the head cell holds the whole pool and all other cells are empty
`include "assert_macros.svh"

module free_range_slot_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] free_index
  input  logic        s_axis_tuser_i,   // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] alloc_index, [16:8] free_slots, rest zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  frsa_pkg::state_e state_q, state_d;
  frsa_pkg::cmd_e   cmd_q;
  frsa_pkg::cmp_t   slot_q;
  frsa_pkg::ctrl_t  ctrl;

  logic [frsa_pkg::FREE_W-1:0] free_total_q, free_total_d;

  logic                          out_valid_q;
  logic [frsa_pkg::ALLOC_W-1:0]  out_alloc_q, out_alloc_d;
  frsa_pkg::status_e             out_status_q, out_status_d;
  logic [frsa_pkg::FS_W-1:0]     out_free_q;

  frsa_pkg::range_t range_w [frsa_pkg::MAX_RANGES];
  frsa_pkg::flags_t flags_w [frsa_pkg::MAX_RANGES];
  logic             le_w    [frsa_pkg::MAX_RANGES];

  logic [frsa_pkg::MAX_RANGES-1:0] hit_v, join_lo_v, join_hi_v, prev_v, pos_v;
  logic                            any_hit, any_join_lo, any_join_hi;

  logic              in_xfer, fire;
  frsa_pkg::cell_op_e dec_op;

  // input and result transfers
  assign fire    = !out_valid_q || m_axis_tready_i;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // chain of cells, the ends see empty neighbors
  for (genvar i = 0; i < frsa_pkg::MAX_RANGES; i++) begin : g_cell
    frsa_pkg::range_t left_r, right_r;
    logic             left_le, right_le;

    if (i == 0) begin : g_first
      assign left_r  = '0;
      assign left_le = 1'b1;
    end else begin : g_mid_l
      assign left_r  = range_w[i-1];
      assign left_le = le_w[i-1];
    end

    if (i == frsa_pkg::MAX_RANGES - 1) begin : g_last
      assign right_r  = '0;
      assign right_le = 1'b0;
    end else begin : g_mid_r
      assign right_r  = range_w[i+1];
      assign right_le = le_w[i+1];
    end

    frsa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .head_i     (i == 0),
      .ctrl_i     (ctrl),
      .left_i     (left_r),
      .right_i    (right_r),
      .left_le_i  (left_le),
      .right_le_i (right_le),
      .le_o       (le_w[i]),
      .range_o    (range_w[i]),
      .flags_o    (flags_w[i])
    );
  end

  // gather the registered cell flags
  always_comb begin
    for (int i = 0; i < frsa_pkg::MAX_RANGES; i++) begin
      hit_v[i]     = flags_w[i].hit;
      join_lo_v[i] = flags_w[i].join_lo;
      join_hi_v[i] = flags_w[i].join_hi;
      prev_v[i]    = flags_w[i].prev;
      pos_v[i]     = flags_w[i].pos;
    end
  end

  assign any_hit     = |hit_v;
  assign any_join_lo = |join_lo_v;
  assign any_join_hi = |join_hi_v;

  // command decode in the update step
  always_comb begin
    dec_op       = frsa_pkg::OP_NONE;
    out_status_d = frsa_pkg::ST_DONE;
    out_alloc_d  = '0;
    free_total_d = free_total_q;
    if (cmd_q == frsa_pkg::CMD_ALLOC) begin
      if (!range_w[0].valid) begin
        out_status_d = frsa_pkg::ST_EXHAUSTED;
      end else begin
        out_alloc_d  = frsa_pkg::ALLOC_W'(range_w[0].first);
        dec_op       = (range_w[0].first >= range_w[0].last) ? frsa_pkg::OP_DROP_ALL
                                                             : frsa_pkg::OP_INC_HEAD;
        free_total_d = free_total_q - frsa_pkg::FREE_W'(1);
      end
    end else begin
      if ((slot_q >= frsa_pkg::CMP_W'(frsa_pkg::NUM_SLOTS)) || any_hit) begin
        out_status_d = frsa_pkg::ST_ALREADY_FREE;
      end else if (!any_join_lo && !any_join_hi &&
                   range_w[frsa_pkg::MAX_RANGES-1].valid) begin
        out_status_d = frsa_pkg::ST_EXHAUSTED;
      end else begin
        if (any_join_lo && any_join_hi) begin
          dec_op = frsa_pkg::OP_MERGE;
        end else if (any_join_lo) begin
          dec_op = frsa_pkg::OP_SET_LAST;
        end else if (any_join_hi) begin
          dec_op = frsa_pkg::OP_SET_FIRST;
        end else begin
          dec_op = frsa_pkg::OP_INSERT;
        end
        free_total_d = free_total_q + frsa_pkg::FREE_W'(1);
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frsa_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) state_d = frsa_pkg::S_CMP;
      end
      frsa_pkg::S_CMP: begin
        state_d = frsa_pkg::S_UPD;
      end
      frsa_pkg::S_UPD: begin
        if (fire) state_d = s_axis_tvalid_i ? frsa_pkg::S_CMP : frsa_pkg::S_IDLE;
      end
      default: begin
        state_d = frsa_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    ctrl.cmp_en     = 1'b0;
    ctrl.op         = frsa_pkg::OP_NONE;
    ctrl.slot       = slot_q;
    case (state_q)
      frsa_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      frsa_pkg::S_CMP: begin
        ctrl.cmp_en = 1'b1;
      end
      frsa_pkg::S_UPD: begin
        s_axis_tready_o = fire;
        if (fire) ctrl.op = dec_op;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frsa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= frsa_pkg::cmd_e'(s_axis_tuser_i);
      slot_q <= frsa_pkg::CMP_W'(s_axis_tdata_i);
    end
  end

  // free slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_total_q <= frsa_pkg::FREE_W'(frsa_pkg::NUM_SLOTS);
    end else if ((state_q == frsa_pkg::S_UPD) && fire) begin
      free_total_q <= free_total_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == frsa_pkg::S_UPD) && fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == frsa_pkg::S_UPD) && fire) begin
      out_alloc_q  <= out_alloc_d;
      out_status_q <= out_status_d;
      out_free_q   <= frsa_pkg::FS_W'(free_total_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_free_q, out_alloc_q};
  assign m_axis_tuser_o  = out_status_q;

  // checks on the sequencer and the range chain
  `FRSA_ASSERT_NXT(a_cmp_after_xfer, in_xfer, state_q == frsa_pkg::S_CMP,
                   "compare step does not follow an input transfer")
  `FRSA_ASSERT(a_one_prev, $onehot0(prev_v), "more than one range below the slot")
  `FRSA_ASSERT(a_one_pos, $onehot0(pos_v), "more than one insert position")
  `FRSA_ASSERT(a_empty_pool, (free_total_q == '0) == !range_w[0].valid,
               "free count and head range disagree")
  `FRSA_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q == frsa_pkg::S_UPD),
                   "result raised outside the update step")

endmodule

FILE: test/tb_free_range_slot_allocator_unit.sv
// testbench for free_range_slot_allocator_unit: random stream stimulus and a range-list predictor
// depends on frsa_pkg and the design files; nothing else is read
`timescale 1ns / 1ps

module tb_free_range_slot_allocator_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHURN_ITEMS    = 360;
  localparam int DRAIN_CYCLES   = 20;

  // one expected result of a command
  typedef struct packed {
    logic [frsa_pkg::ALLOC_W-1:0] alloc_slot;
    frsa_pkg::status_e            status;
    logic [frsa_pkg::FS_W-1:0]    free_slots;
  } pool_result_t;

  // predicts every result from the accepted commands and checks the results in order
  class slot_pool_scoreboard;
    frsa_pkg::idx_t span_first[frsa_pkg::MAX_RANGES];
    frsa_pkg::idx_t span_last[frsa_pkg::MAX_RANGES];
    int             span_cnt;
    int             free_cnt;
    pool_result_t   pending[$];
    int             errors;
    int             results_seen;

    function new();
      for (int i = 0; i < frsa_pkg::MAX_RANGES; i++) begin
        span_first[i] = '0;
        span_last[i]  = '0;
      end
      span_last[0] = frsa_pkg::idx_t'(frsa_pkg::NUM_SLOTS - 1);
      span_cnt     = 1;
      free_cnt     = frsa_pkg::NUM_SLOTS;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int free_count();
      return free_cnt;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    function bit is_free(frsa_pkg::idx_t slot);
      for (int i = 0; i < span_cnt; i++) begin
        if (slot >= span_first[i] && slot <= span_last[i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // close the gap left by an emptied range
    function void remove_span(int pos);
      for (int i = pos; i + 1 < span_cnt && i + 1 < frsa_pkg::MAX_RANGES; i++) begin
        span_first[i] = span_first[i+1];
        span_last[i]  = span_last[i+1];
      end
      if (span_cnt > 0) span_cnt--;
    endfunction

    // open a one-slot range at pos
    function void insert_span(int pos, frsa_pkg::idx_t slot);
      for (int i = span_cnt; i > pos; i--) begin
        span_first[i] = span_first[i-1];
        span_last[i]  = span_last[i-1];
      end
      span_first[pos] = slot;
      span_last[pos]  = slot;
      span_cnt++;
    endfunction

    // return a slot to the pool: grow, bridge or insert
    function frsa_pkg::status_e give_back(frsa_pkg::idx_t slot);
      int pos;
      bit lo_adj;
      bit hi_adj;
      pos = 0;
      if (int'(slot) >= frsa_pkg::NUM_SLOTS) return frsa_pkg::ST_ALREADY_FREE;
      while (pos < span_cnt && span_first[pos] <= slot) pos++;
      if (pos > 0 && slot <= span_last[pos-1]) return frsa_pkg::ST_ALREADY_FREE;
      lo_adj = pos > 0 && int'(span_last[pos-1]) + 1 == int'(slot);
      hi_adj = pos < span_cnt && int'(span_first[pos]) == int'(slot) + 1;
      if (lo_adj && hi_adj) begin
        span_last[pos-1] = span_last[pos];
        remove_span(pos);
      end else if (lo_adj) begin
        span_last[pos-1] = slot;
      end else if (hi_adj) begin
        span_first[pos] = slot;
      end else begin
        if (span_cnt >= frsa_pkg::MAX_RANGES) return frsa_pkg::ST_EXHAUSTED;
        insert_span(pos, slot);
      end
      free_cnt++;
      return frsa_pkg::ST_DONE;
    endfunction

    // note one accepted command and queue the result it must produce
    function void note_cmd(frsa_pkg::cmd_e cmd, frsa_pkg::idx_t slot);
      pool_result_t r;
      r.alloc_slot = '0;
      r.status     = frsa_pkg::ST_DONE;
      if (cmd == frsa_pkg::CMD_ALLOC) begin
        if (span_cnt == 0) begin
          r.status = frsa_pkg::ST_EXHAUSTED;
        end else begin
          r.alloc_slot = span_first[0];
          if (span_first[0] >= span_last[0]) remove_span(0);
          else span_first[0]++;
          if (free_cnt > 0) free_cnt--;
        end
      end else begin
        r.status = give_back(slot);
      end
      r.free_slots = free_cnt[frsa_pkg::FS_W-1:0];
      pending.insert(pending.size(), r);
    endfunction

    task report(string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      errors++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_result(logic [frsa_pkg::ALLOC_W-1:0] alloc_slot,
                      logic [frsa_pkg::STATUS_W-1:0] status,
                      logic [frsa_pkg::FS_W-1:0] free_slots);
      pool_result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        report("result with no command outstanding");
      end else begin
        exp_r = pending.pop_front();
        if (alloc_slot !== exp_r.alloc_slot)
          report($sformatf("alloc_index got %0d, want %0d", alloc_slot, exp_r.alloc_slot));
        if (status !== exp_r.status)
          report($sformatf("status got %0d, want %s", status, exp_r.status.name()));
        if (free_slots !== exp_r.free_slots)
          report($sformatf("free_slots got %0d, want %0d", free_slots, exp_r.free_slots));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] free_index
  logic        s_axis_tuser_i;   // [0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // [7:0] alloc_index, [16:8] free_slots, rest zero
  logic [1:0]  m_axis_tuser_o;   // [1:0] status

  slot_pool_scoreboard sb;
  bit                  no_idle;
  int                  idle_cycles = 0;

  free_range_slot_allocator_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // a slot that is most likely in use, sometimes any slot
  function automatic frsa_pkg::idx_t pick_busy_slot();
    frsa_pkg::idx_t s;
    s = frsa_pkg::idx_t'($urandom);
    if ($urandom_range(0, 9) == 0) return s;
    for (int tries = 0; tries < 8; tries++) begin
      s = frsa_pkg::idx_t'($urandom);
      if (!sb.is_free(s)) return s;
    end
    return s;
  endfunction

  // one command transfer on the input side; entered and left at a falling edge
  task automatic send_cmd(frsa_pkg::cmd_e cmd, frsa_pkg::idx_t slot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= slot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_cmd(cmd, slot);
    @(negedge clk_i);
  endtask

  // free the listed slots in random order
  task automatic free_shuffled(ref frsa_pkg::idx_t slots[$]);
    frsa_pkg::idx_t tmp;
    int             j;
    for (int i = slots.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    foreach (slots[i]) send_cmd(frsa_pkg::CMD_FREE, slots[i]);
  endtask

  // result side: ready in random stretches, stalls mostly short
  initial begin
    int  run;
    bit  level;
    m_axis_tready_i = 1'b0;
    run   = 0;
    level = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        if (no_idle || !level) begin
          level = 1'b1;
          run   = no_idle ? 1 : $urandom_range(1, 12);
        end else begin
          run   = pick_gap();
          level = (run == 0);
          if (run == 0) run = $urandom_range(1, 12);
        end
      end
      m_axis_tready_i <= level;
      run--;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o[7:0], m_axis_tuser_o, m_axis_tdata_o[16:8]);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus
  initial begin
    frsa_pkg::idx_t slots[$];
    int             churn_items;
    int             seg_len;
    int             target_busy;
    bit             want_alloc;

    sb              = new();
    no_idle         = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = frsa_pkg::CMD_ALLOC;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // frees into a full pool are answered as already free
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(0));
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(255));
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(128));
    // take 0..3, then give them back through the insert, grow-downward and bridge paths
    repeat (4) send_cmd(frsa_pkg::CMD_ALLOC, frsa_pkg::idx_t'($urandom));
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(1));   // new one-slot range
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(3));   // grows the range above downward
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(0));   // grows the one-slot range downward
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(2));   // bridges two ranges
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(2));   // already free
    repeat (2) send_cmd(frsa_pkg::CMD_ALLOC, frsa_pkg::idx_t'($urandom));
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(0));   // new range at the head
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(1));   // bridges again

    // empty the pool and ask past the end
    while (sb.free_count() > 0) send_cmd(frsa_pkg::CMD_ALLOC, frsa_pkg::idx_t'($urandom));
    repeat (3) send_cmd(frsa_pkg::CMD_ALLOC, frsa_pkg::idx_t'($urandom));

    // even slots plus the top one: the range list fills to its limit
    for (int s = 0; s < frsa_pkg::NUM_SLOTS; s += 2)
      slots.insert(slots.size(), frsa_pkg::idx_t'(s));
    slots.insert(slots.size(), frsa_pkg::idx_t'(frsa_pkg::NUM_SLOTS - 1));
    free_shuffled(slots);
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(0));
    send_cmd(frsa_pkg::CMD_ALLOC, frsa_pkg::idx_t'($urandom));
    send_cmd(frsa_pkg::CMD_FREE, frsa_pkg::idx_t'(0));
    // odd slots: each one bridges two ranges
    slots.delete();
    for (int s = 1; s < frsa_pkg::NUM_SLOTS - 1; s += 2)
      slots.insert(slots.size(), frsa_pkg::idx_t'(s));
    free_shuffled(slots);

    // random churn toward a changing fill level
    churn_items = 0;
    while (churn_items < CHURN_ITEMS) begin
      seg_len     = $urandom_range(30, 120);
      target_busy = $urandom_range(0, frsa_pkg::NUM_SLOTS);
      no_idle     = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len; k++) begin
        if (frsa_pkg::NUM_SLOTS - sb.free_count() < target_busy)
          want_alloc = $urandom_range(0, 9) < 8;
        else want_alloc = $urandom_range(0, 9) < 2;
        if (want_alloc) send_cmd(frsa_pkg::CMD_ALLOC, frsa_pkg::idx_t'($urandom));
        else send_cmd(frsa_pkg::CMD_FREE, pick_busy_slot());
        churn_items++;
      end
    end
    no_idle = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    // wait for the outstanding results, then watch for strays
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
